### hdl/tdpc_pkg.sv
// ----------------------------------------------------------------------------
// Ticket dispenser payout controller package
// Shared types, register indexes and constants for the payout controller.
// ----------------------------------------------------------------------------
package tdpc_pkg;

    localparam int unsigned CountW   = 16;
    localparam int unsigned DebW     = 8;
    localparam int unsigned TotalW   = 20;
    localparam int unsigned CfgIdxW  = 2;
    localparam int unsigned CfgDataW = 16;

    localparam logic [CountW-1:0] COUNT_MAX     = '1;
    localparam logic [DebW-1:0]   DEB_MAX       = '1;
    localparam logic [TotalW-1:0] TOTAL_MAX     = 20'd999999;
    localparam logic [CountW-1:0] BLOCK_LIM_RST = 16'd1000;
    localparam logic [CountW-1:0] EMPTY_LIM_RST = 16'd600;
    localparam logic [DebW-1:0]   DEB_TICKS_RST = 8'd1;

    // Configuration register indexes
    typedef enum logic [CfgIdxW-1:0] {
        CFG_NORMAL_LEVEL   = 2'd0,
        CFG_BLOCK_LIMIT    = 2'd1,
        CFG_EMPTY_LIMIT    = 2'd2,
        CFG_DEBOUNCE_TICKS = 2'd3
    } t_cfg_idx;

    // Request codes
    typedef enum logic {
        REQ_TICK = 1'b0,
        REQ_LOAD = 1'b1
    } t_req;

    typedef struct packed {
        logic              normal_level;
        logic [CountW-1:0] block_limit;
        logic [CountW-1:0] empty_limit;
        logic [DebW-1:0]   debounce_ticks;
    } t_cfg;

    typedef struct packed {
        logic              req_type;
        logic              sensor_level;
        logic [CountW-1:0] ticket_amount;
    } t_item;

    typedef struct packed {
        logic [CountW-1:0] jam_count;
        logic [CountW-1:0] empty_count;
        logic [DebW-1:0]   debounce_count;
        logic              last_level;
        logic              payout_enabled;
        logic [CountW-1:0] owed_count;
        logic [TotalW-1:0] total_count;
        logic              jam_err;
        logic              empty_err;
        logic              motor_state;
    } t_state;

    typedef struct packed {
        logic              motor_on;
        logic [CountW-1:0] tickets_owed;
        logic [TotalW-1:0] tickets_total;
        logic              jam_error;
        logic              empty_error;
        logic              ticket_paid;
        logic              save_request;
    } t_result;

endpackage

### hdl/tdpc_cfg_regs.sv
// ----------------------------------------------------------------------------
// Payout controller configuration registers
// Write-only register bank holding the sensor level and the three limits.
// ----------------------------------------------------------------------------
module tdpc_cfg_regs (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [tdpc_pkg::CfgIdxW-1:0]   i_cfg_idx,
    input  logic [tdpc_pkg::CfgDataW-1:0]  i_cfg_data,
    output tdpc_pkg::t_cfg                 o_cfg
);

    tdpc_pkg::t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.normal_level   <= 1'b1;
            r_cfg.block_limit    <= tdpc_pkg::BLOCK_LIM_RST;
            r_cfg.empty_limit    <= tdpc_pkg::EMPTY_LIM_RST;
            r_cfg.debounce_ticks <= tdpc_pkg::DEB_TICKS_RST;
        end else if (i_cfg_we) begin
            unique case (tdpc_pkg::t_cfg_idx'(i_cfg_idx))
                tdpc_pkg::CFG_NORMAL_LEVEL:   r_cfg.normal_level   <= i_cfg_data[0];
                tdpc_pkg::CFG_BLOCK_LIMIT:    r_cfg.block_limit    <= i_cfg_data;
                tdpc_pkg::CFG_EMPTY_LIMIT:    r_cfg.empty_limit    <= i_cfg_data;
                tdpc_pkg::CFG_DEBOUNCE_TICKS: begin
                    r_cfg.debounce_ticks <= i_cfg_data[tdpc_pkg::DebW-1:0];
                end
                default: ;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

### hdl/tdpc_step.sv
// ----------------------------------------------------------------------------
// Payout controller update logic
// Computes the next controller state and the result for one transaction.
// ----------------------------------------------------------------------------
module tdpc_step (
    input  tdpc_pkg::t_cfg    i_cfg,
    input  tdpc_pkg::t_item   i_item,
    input  tdpc_pkg::t_state  i_state,
    output tdpc_pkg::t_state  o_state,
    output tdpc_pkg::t_result o_result
);

    logic                              paid;
    logic                              save;
    logic [tdpc_pkg::CountW:0]         owed_sum;
    logic                              s;
    logic                              n;
    logic                              done;
    tdpc_pkg::t_state                  st;

    always_comb begin
        st       = i_state;
        paid     = 1'b0;
        save     = 1'b0;
        done     = 1'b0;
        s        = i_item.sensor_level;
        n        = i_cfg.normal_level;
        owed_sum = {1'b0, i_state.owed_count} + {1'b0, i_item.ticket_amount};

        if (i_item.req_type == tdpc_pkg::REQ_LOAD) begin
            st.owed_count     = owed_sum[tdpc_pkg::CountW] ? tdpc_pkg::COUNT_MAX
                                                           : owed_sum[tdpc_pkg::CountW-1:0];
            st.payout_enabled = 1'b1;
        end else begin
            // Jam supervision: sensor held away from its resting level.
            if (s != n) begin
                if (st.jam_count != tdpc_pkg::COUNT_MAX) begin
                    st.jam_count = st.jam_count + 1'b1;
                end
                if (st.jam_count >= i_cfg.block_limit) begin
                    st.jam_count      = i_cfg.block_limit;
                    st.payout_enabled = 1'b0;
                    st.motor_state    = 1'b0;
                    st.jam_err        = 1'b1;
                end
            end else begin
                st.jam_count = '0;
                st.jam_err   = 1'b0;
            end

            // Empty timeout while paying out.
            if (st.payout_enabled) begin
                if (st.empty_count != tdpc_pkg::COUNT_MAX) begin
                    st.empty_count = st.empty_count + 1'b1;
                end
                if (st.empty_count >= i_cfg.empty_limit) begin
                    st.payout_enabled = 1'b0;
                    st.empty_count    = '0;
                    st.empty_err      = 1'b1;
                    st.motor_state    = 1'b0;
                end
            end

            priority if (st.jam_err) begin
                done = 1'b1;
            end else if (!st.payout_enabled) begin
                st.motor_state = 1'b0;
                done           = 1'b1;
            end else if (st.owed_count == '0) begin
                save              = 1'b1;
                st.empty_count    = '0;
                st.payout_enabled = 1'b0;
                st.empty_err      = 1'b0;
                st.motor_state    = 1'b0;
                done              = 1'b1;
            end else begin
                st.motor_state = 1'b1;
            end

            if (!done) begin
                if (st.last_level == s) begin
                    if (s == n) begin
                        st.debounce_count = '0;
                    end
                end else begin
                    if (st.debounce_count != tdpc_pkg::DEB_MAX) begin
                        st.debounce_count = st.debounce_count + 1'b1;
                    end
                    if (st.debounce_count >= i_cfg.debounce_ticks) begin
                        st.last_level = s;
                        if (s == n) begin
                            st.owed_count  = st.owed_count - 1'b1;
                            st.total_count = (st.total_count < tdpc_pkg::TOTAL_MAX)
                                             ? st.total_count + 1'b1 : '0;
                            paid           = 1'b1;
                            save           = 1'b1;
                            st.empty_count = '0;
                            st.empty_err   = 1'b0;
                        end
                        st.debounce_count = '0;
                    end
                end
            end
        end

        o_state                = st;
        o_result.motor_on      = st.motor_state;
        o_result.tickets_owed  = st.owed_count;
        o_result.tickets_total = st.total_count;
        o_result.jam_error     = st.jam_err;
        o_result.empty_error   = st.empty_err;
        o_result.ticket_paid   = paid;
        o_result.save_request  = save;
    end

endmodule

### hdl/ticket_dispenser_payout_controller.sv
// ----------------------------------------------------------------------------
// Ticket dispenser payout controller
// A transaction is captured in the input register, then its result in the result register.
// Throughput: one transaction per cycle, limited only by the output stall.
// Reset (synchronous, active low) clears all counters, errors and the motor,
// sets the last accepted sensor level high and restores the register defaults.
// ----------------------------------------------------------------------------
module ticket_dispenser_payout_controller (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // Configuration write port
    input  logic                                i_cfg_we,
    input  logic [tdpc_pkg::CfgIdxW-1:0]        i_cfg_idx,
    input  logic [tdpc_pkg::CfgDataW-1:0]       i_cfg_data,
    // Request channel
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  logic                                i_req_type,
    input  logic                                i_sensor_level,
    input  logic [tdpc_pkg::CountW-1:0]         i_ticket_amount,
    // Result channel
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output logic                                o_motor_on,
    output logic [tdpc_pkg::CountW-1:0]         o_tickets_owed,
    output logic [tdpc_pkg::TotalW-1:0]         o_tickets_total,
    output logic                                o_jam_error,
    output logic                                o_empty_error,
    output logic                                o_ticket_paid,
    output logic                                o_save_request
);

    // The design is a two-register pipeline. An incoming transaction is first
    // captured in the input register. From there the update logic works out
    // the new controller state and the result in one pass; both are written
    // at the same edge, so the next transaction in the input register already
    // sees the updated counters and can follow in the very next cycle.

    tdpc_pkg::t_cfg    cfg;
    tdpc_pkg::t_item   r_item;
    logic              r_in_valid;
    tdpc_pkg::t_state  r_state;
    tdpc_pkg::t_state  n_state;
    tdpc_pkg::t_state  rst_state;
    tdpc_pkg::t_result n_result;
    tdpc_pkg::t_result r_result;
    logic              r_out_valid;
    logic              out_free;
    logic              advance;

    tdpc_cfg_regs u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_cfg      (cfg)
    );

    tdpc_step u_step (
        .i_cfg    (cfg),
        .i_item   (r_item),
        .i_state  (r_state),
        .o_state  (n_state),
        .o_result (n_result)
    );

    // The result register can take a new value when it is empty or its
    // current transaction is being taken downstream this cycle.
    assign out_free   = !r_out_valid || !i_out_stall;
    // The held transaction moves into the result register, updating state.
    assign advance    = r_in_valid && out_free;
    // The input register stalls only when it is full and cannot drain.
    assign o_in_stall = r_in_valid && !out_free;

    // Input register: control bit under reset, payload captured on acceptance.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (!o_in_stall) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && !o_in_stall) begin
            r_item.req_type      <= i_req_type;
            r_item.sensor_level  <= i_sensor_level;
            r_item.ticket_amount <= i_ticket_amount;
        end
    end

    // Reset value of the controller state: everything clear apart from the
    // last accepted sensor level, which starts at the reset normal level.
    always_comb begin
        rst_state            = '0;
        rst_state.last_level = 1'b1;
    end

    // Controller state is committed only when a transaction is processed.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= rst_state;
        end else if (advance) begin
            r_state <= n_state;
        end
    end

    // Result register with its valid flag.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_result <= n_result;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_motor_on      = r_result.motor_on;
    assign o_tickets_owed  = r_result.tickets_owed;
    assign o_tickets_total = r_result.tickets_total;
    assign o_jam_error     = r_result.jam_error;
    assign o_empty_error   = r_result.empty_error;
    assign o_ticket_paid   = r_result.ticket_paid;
    assign o_save_request  = r_result.save_request;

endmodule
